@@ hdl/u8alc_pkg.sv @@
// Package for the UTF-8 letter range check unit.
// Holds decoder state type, byte pattern constants and the code point range test.
// No dependencies.
`default_nettype none

package u8alc_pkg;

   // Position within a three-byte sequence
   localparam logic [1:0] POS_LEAD = 2'd0;
   localparam logic [1:0] POS_MID  = 2'd1;
   localparam logic [1:0] POS_LAST = 2'd2;

   // Byte class masks and patterns
   localparam logic [7:0] LEAD_MASK = 8'hF0;
   localparam logic [7:0] LEAD_PAT  = 8'hE0;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_PAT  = 8'h80;

   // Accepted code point ranges
   localparam logic [15:0] RANGE_A_LO = 16'h0621;
   localparam logic [15:0] RANGE_A_HI = 16'h064A;
   localparam logic [15:0] RANGE_B_LO = 16'h0660;
   localparam logic [15:0] RANGE_B_HI = 16'h0669;
   localparam logic [15:0] RANGE_C_LO = 16'h066E;
   localparam logic [15:0] RANGE_C_HI = 16'h06D3;

   typedef struct packed {
      logic [1:0] seq_position;
      logic [3:0] lead_bits;
      logic [5:0] middle_bits;
      logic       failed;
   } dec_state_type;

   localparam dec_state_type DEC_STATE_RESET = '{
      seq_position: POS_LEAD, lead_bits: 4'd0, middle_bits: 6'd0, failed: 1'b0
   };

   // Input item as held in the stage register
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } req_item_type;

   function automatic logic cp_accepted(input logic [15:0] cp);
      cp_accepted = ((cp >= RANGE_A_LO) && (cp <= RANGE_A_HI))
                 || ((cp >= RANGE_B_LO) && (cp <= RANGE_B_HI))
                 || ((cp >= RANGE_C_LO) && (cp <= RANGE_C_HI));
   endfunction

endpackage

`default_nettype wire

@@ hdl/u8alc_if.sv @@
// Valid/ready channel interfaces for the byte input and the answer output.
// No dependencies.
`default_nettype none

interface u8alc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       is_last;

   modport source (output valid, data_byte, has_byte, is_last, input ready);
   modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface u8alc_rsp_if;
   logic valid;
   logic ready;
   logic all_arabic;

   modport source (output valid, all_arabic, input ready);
   modport sink   (input valid, all_arabic, output ready);
endinterface

`default_nettype wire

@@ hdl/u8alc_step.sv @@
// One decode step: next decoder state and string answer for one item.
// Depends on u8alc_pkg.
`default_nettype none

module u8alc_step
   import u8alc_pkg::*;
(
   input  dec_state_type cur_state,
   input  req_item_type  item,
   output dec_state_type next_state,
   output logic          answer
);

   dec_state_type upd;
   logic [15:0]   cp;
   logic          is_cont;
   logic          is_lead;

   assign is_cont = (item.data_byte & CONT_MASK) == CONT_PAT;
   assign is_lead = (item.data_byte & LEAD_MASK) == LEAD_PAT;
   assign cp      = {cur_state.lead_bits, cur_state.middle_bits, item.data_byte[5:0]};

   // Byte decode
   always_comb begin
      upd = cur_state;
      if (item.has_byte) begin
         unique case (cur_state.seq_position)
            POS_MID: begin
               if (is_cont) begin
                  upd.middle_bits  = item.data_byte[5:0];
                  upd.seq_position = POS_LAST;
               end else begin
                  upd.failed       = 1'b1;
                  upd.seq_position = POS_LEAD;
               end
            end
            POS_LAST: begin
               if (!is_cont || !cp_accepted(cp)) begin
                  upd.failed = 1'b1;
               end
               upd.seq_position = POS_LEAD;
            end
            // lead position, unused code acts the same
            default: begin
               if (is_lead) begin
                  upd.lead_bits    = item.data_byte[3:0];
                  upd.seq_position = POS_MID;
               end else begin
                  upd.failed       = 1'b1;
                  upd.seq_position = POS_LEAD;
               end
            end
         endcase
      end
   end

   // Answer and end-of-string clear
   assign answer     = !upd.failed && (upd.seq_position == POS_LEAD);
   assign next_state = item.is_last ? DEC_STATE_RESET : upd;

endmodule

`default_nettype wire

@@ hdl/utf8_arabic_letter_check_unit.sv @@
// Top level of the UTF-8 letter range check unit: input stage, decoder, answer register.
// Depends on u8alc_pkg, u8alc_if and u8alc_step.
//
//  channel   dir  payload                         handshake
//  req_ch    in   data_byte[7:0] has_byte is_last valid/ready
//  rsp_ch    out  all_arabic                      valid/ready
//
// One byte per cycle while no stalled answer blocks; the decoder loop (u8alc_step) sets it.
// The last item passes the input stage register, then the answer register raises valid.
// Synchronous active-high reset clears the decoder state and both valid flags.
// A stalled answer holds the stage; the stage still drains items that end no string.
`default_nettype none

module utf8_arabic_letter_check_unit
   import u8alc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   u8alc_req_if.sink   req_ch,
   u8alc_rsp_if.source rsp_ch
);

   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff;
   dec_state_type st_ff, st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ans_ff;
   logic          step_answer;
   logic          s1_fire;
   logic          req_fire;
   logic          rsp_free;

   u8alc_step u_step (
      .cur_state  (st_ff),
      .item       (s1_item_ff),
      .next_state (st_in),
      .answer     (step_answer)
   );

   // Stage advance control
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && (!s1_item_ff.is_last || rsp_free);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = (s1_fire && s1_item_ff.is_last) || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= DEC_STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            st_ff <= st_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= '{data_byte: req_ch.data_byte, has_byte: req_ch.has_byte,
                         is_last: req_ch.is_last};
      end
      if (s1_fire && s1_item_ff.is_last) begin
         rsp_ans_ff <= step_answer;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.all_arabic = rsp_ans_ff;

   // Checks
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_item_ff.is_last |=> st_ff == DEC_STATE_RESET)
      else $error("decoder state not cleared after string end");

   a_pos_legal: assert property (@(posedge clock) disable iff (reset)
      st_ff.seq_position != 2'd3)
      else $error("unused sequence position reached");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && s1_item_ff.is_last && rsp_valid_ff)
      else $error("input stalled without a pending answer");

   a_ans_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_ans_ff))
      else $error("pending answer overwritten");

endmodule

`default_nettype wire
